/* design/gdbt_pkg.sv */
`default_nettype none
package gdbt_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int ROWS = 64;
    localparam int VID_W = 6;
    localparam int CNT_W = 7;
    localparam int ACT_W = 2;

    localparam logic [ACT_W-1:0] ACT_ADD_EDGE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DFS = 2'd1;
    localparam logic [ACT_W-1:0] ACT_BFS = 2'd2;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_EDGE_RDA,
        DP_EDGE_WRA,
        DP_EDGE_RDB,
        DP_EDGE_WRB,
        DP_RUN_INIT,
        DP_SCAN_NEXT,
        DP_DFS_START,
        DP_BFS_START,
        DP_ROW_READ_CUR,
        DP_DFS_PUSH,
        DP_DFS_POP,
        DP_POP_LOAD,
        DP_BFS_DEQ_READ,
        DP_BFS_DEQ_LOAD,
        DP_BFS_ENQ,
        DP_FLUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_edge;
        logic edge_ok;
        logic is_run;
        logic is_dfs;
        logic scan_done;
        logic scan_visited;
        logic cand_found;
        logic depth_one;
        logic fill_zero;
        logic emit_ok;
        logic out_free;
        logic pend_valid;
    } dp_status_t;

endpackage
`default_nettype wire

/* design/gdbt_datapath.sv */
`default_nettype none
module gdbt_datapath #(
    parameter int MAX_VERTICES = gdbt_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire gdbt_pkg::dp_cmd_t             cmd,
    output gdbt_pkg::dp_status_t               sts,
    input  wire logic                          cfg_wr_en,
    input  wire logic [gdbt_pkg::CNT_W-1:0]    cfg_wr_data,
    input  wire logic [gdbt_pkg::ACT_W-1:0]    action,
    input  wire logic [gdbt_pkg::VID_W-1:0]    first_vertex,
    input  wire logic [gdbt_pkg::VID_W-1:0]    second_vertex,
    input  wire logic                          skip_enable,
    input  wire logic [gdbt_pkg::VID_W-1:0]    skip_vertex,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [gdbt_pkg::VID_W-1:0]         vertex,
    output logic                               last_of_run
);

    localparam int NV = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;
    localparam logic [gdbt_pkg::CNT_W-1:0] NV_C = gdbt_pkg::CNT_W'(NV);

    logic [gdbt_pkg::ACT_W-1:0] act_reg;
    logic [gdbt_pkg::VID_W-1:0] a_reg, b_reg, skv_reg;
    logic                       sken_reg;
    logic [gdbt_pkg::CNT_W-1:0] cnt_reg;
    logic [gdbt_pkg::ROWS-1:0]  visited_reg;
    logic [gdbt_pkg::CNT_W-1:0] scan_reg;
    logic [gdbt_pkg::VID_W-1:0] cur_reg;
    logic [gdbt_pkg::CNT_W-1:0] depth_reg;
    logic [gdbt_pkg::VID_W-1:0] head_reg, tail_reg;
    logic [gdbt_pkg::CNT_W-1:0] fill_reg;

    logic [gdbt_pkg::ROWS-1:0]  adj_mem [gdbt_pkg::ROWS];
    logic [gdbt_pkg::ROWS-1:0]  row_valid_reg;
    logic [gdbt_pkg::ROWS-1:0]  rd_row_reg;
    logic                       rowv_reg;
    logic [gdbt_pkg::VID_W-1:0] stk_mem [gdbt_pkg::ROWS];
    logic [gdbt_pkg::VID_W-1:0] stk_rd_reg;
    logic [gdbt_pkg::VID_W-1:0] q_mem [gdbt_pkg::ROWS];
    logic [gdbt_pkg::VID_W-1:0] q_rd_reg;

    logic                       pend_valid_reg;
    logic [gdbt_pkg::VID_W-1:0] pend_vtx_reg;
    logic                       out_valid_reg, last_reg;
    logic [gdbt_pkg::VID_W-1:0] vertex_reg;

    logic                       rd_en;
    logic [gdbt_pkg::VID_W-1:0] rd_addr;
    logic [gdbt_pkg::ROWS-1:0]  row_data, cand;
    logic                       found;
    logic [gdbt_pkg::VID_W-1:0] found_idx;
    logic [gdbt_pkg::CNT_W-1:0] nsat;
    logic                       emit_en;
    logic [gdbt_pkg::VID_W-1:0] emit_vtx;

    assign row_data = rowv_reg ? rd_row_reg : '0;
    assign cand = row_data & ~visited_reg;

    // Lowest set bit of the candidate row.
    always_comb
    begin
        found = 1'b0;
        found_idx = '0;
        for (int i = gdbt_pkg::ROWS - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                found = 1'b1;
                found_idx = gdbt_pkg::VID_W'(i);
            end
        end
    end

    assign nsat = (cnt_reg > NV_C) ? NV_C : cnt_reg;

    always_comb
    begin
        rd_en = 1'b1;
        rd_addr = cur_reg;
        case (cmd.op)
            gdbt_pkg::DP_EDGE_RDA:     rd_addr = a_reg;
            gdbt_pkg::DP_EDGE_RDB:     rd_addr = b_reg;
            gdbt_pkg::DP_ROW_READ_CUR: rd_addr = cur_reg;
            gdbt_pkg::DP_BFS_DEQ_LOAD: rd_addr = q_rd_reg;
            default:                   rd_en = 1'b0;
        endcase
    end

    always_comb
    begin
        emit_en = 1'b0;
        emit_vtx = found_idx;
        case (cmd.op)
            gdbt_pkg::DP_DFS_START:
            begin
                emit_en = 1'b1;
                emit_vtx = scan_reg[gdbt_pkg::VID_W-1:0];
            end
            gdbt_pkg::DP_DFS_PUSH:
            begin
                emit_en = 1'b1;
                emit_vtx = found_idx;
            end
            gdbt_pkg::DP_BFS_DEQ_LOAD:
            begin
                emit_en = 1'b1;
                emit_vtx = q_rd_reg;
            end
            default:
            begin
                emit_en = 1'b0;
            end
        endcase
    end

    // Memories: adjacency rows, DFS stack and BFS queue.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_row_reg <= adj_mem[rd_addr];
        end
        if (cmd.op == gdbt_pkg::DP_EDGE_WRA)
        begin
            adj_mem[a_reg] <= row_data | (gdbt_pkg::ROWS'(1) << b_reg);
        end
        if (cmd.op == gdbt_pkg::DP_EDGE_WRB)
        begin
            adj_mem[b_reg] <= row_data | (gdbt_pkg::ROWS'(1) << a_reg);
        end
        if (cmd.op == gdbt_pkg::DP_DFS_PUSH && depth_reg < gdbt_pkg::CNT_W'(gdbt_pkg::ROWS))
        begin
            stk_mem[gdbt_pkg::VID_W'(depth_reg - 1'b1)] <= cur_reg;
        end
        if (cmd.op == gdbt_pkg::DP_DFS_POP)
        begin
            stk_rd_reg <= stk_mem[gdbt_pkg::VID_W'(depth_reg - 2'd2)];
        end
        if (cmd.op == gdbt_pkg::DP_BFS_START)
        begin
            q_mem[0] <= scan_reg[gdbt_pkg::VID_W-1:0];
        end
        if (cmd.op == gdbt_pkg::DP_BFS_ENQ && fill_reg < gdbt_pkg::CNT_W'(gdbt_pkg::ROWS))
        begin
            q_mem[tail_reg] <= found_idx;
        end
        if (cmd.op == gdbt_pkg::DP_BFS_DEQ_READ)
        begin
            q_rd_reg <= q_mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == gdbt_pkg::DP_CAPTURE)
        begin
            act_reg <= action;
            a_reg <= first_vertex;
            b_reg <= second_vertex;
            sken_reg <= skip_enable;
            skv_reg <= skip_vertex;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= gdbt_pkg::CNT_W'(gdbt_pkg::ROWS);
            row_valid_reg <= '0;
            rowv_reg <= 1'b0;
            visited_reg <= '0;
            scan_reg <= '0;
            cur_reg <= '0;
            depth_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
            pend_valid_reg <= 1'b0;
            pend_vtx_reg <= '0;
            out_valid_reg <= 1'b0;
            vertex_reg <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cnt_reg <= cfg_wr_data;
            end
            if (rd_en)
            begin
                rowv_reg <= row_valid_reg[rd_addr];
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (emit_en)
            begin
                if (pend_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                    vertex_reg <= pend_vtx_reg;
                    last_reg <= 1'b0;
                end
                pend_valid_reg <= 1'b1;
                pend_vtx_reg <= emit_vtx;
            end
            case (cmd.op)
                gdbt_pkg::DP_EDGE_WRA:
                begin
                    row_valid_reg[a_reg] <= 1'b1;
                end
                gdbt_pkg::DP_EDGE_WRB:
                begin
                    row_valid_reg[b_reg] <= 1'b1;
                end
                gdbt_pkg::DP_RUN_INIT:
                begin
                    visited_reg <= sken_reg ? (gdbt_pkg::ROWS'(1) << skv_reg) : '0;
                    scan_reg <= '0;
                end
                gdbt_pkg::DP_SCAN_NEXT:
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
                gdbt_pkg::DP_DFS_START:
                begin
                    visited_reg[scan_reg[gdbt_pkg::VID_W-1:0]] <= 1'b1;
                    cur_reg <= scan_reg[gdbt_pkg::VID_W-1:0];
                    depth_reg <= gdbt_pkg::CNT_W'(1);
                end
                gdbt_pkg::DP_BFS_START:
                begin
                    visited_reg[scan_reg[gdbt_pkg::VID_W-1:0]] <= 1'b1;
                    head_reg <= '0;
                    tail_reg <= gdbt_pkg::VID_W'(1);
                    fill_reg <= gdbt_pkg::CNT_W'(1);
                end
                gdbt_pkg::DP_DFS_PUSH:
                begin
                    visited_reg[found_idx] <= 1'b1;
                    if (depth_reg < gdbt_pkg::CNT_W'(gdbt_pkg::ROWS))
                    begin
                        cur_reg <= found_idx;
                        depth_reg <= depth_reg + 1'b1;
                    end
                end
                gdbt_pkg::DP_DFS_POP:
                begin
                    depth_reg <= depth_reg - 1'b1;
                end
                gdbt_pkg::DP_POP_LOAD:
                begin
                    cur_reg <= stk_rd_reg;
                end
                gdbt_pkg::DP_BFS_DEQ_READ:
                begin
                    head_reg <= head_reg + 1'b1;
                    fill_reg <= fill_reg - 1'b1;
                end
                gdbt_pkg::DP_BFS_ENQ:
                begin
                    if (fill_reg < gdbt_pkg::CNT_W'(gdbt_pkg::ROWS))
                    begin
                        visited_reg[found_idx] <= 1'b1;
                        tail_reg <= tail_reg + 1'b1;
                        fill_reg <= fill_reg + 1'b1;
                    end
                end
                gdbt_pkg::DP_FLUSH:
                begin
                    out_valid_reg <= 1'b1;
                    vertex_reg <= pend_vtx_reg;
                    last_reg <= 1'b1;
                    pend_valid_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        sts.is_edge = (act_reg == gdbt_pkg::ACT_ADD_EDGE);
        sts.edge_ok = ({1'b0, a_reg} < NV_C) && ({1'b0, b_reg} < NV_C);
        sts.is_run = (act_reg == gdbt_pkg::ACT_DFS) || (act_reg == gdbt_pkg::ACT_BFS);
        sts.is_dfs = (act_reg == gdbt_pkg::ACT_DFS);
        sts.scan_done = (scan_reg >= nsat);
        sts.scan_visited = visited_reg[scan_reg[gdbt_pkg::VID_W-1:0]];
        sts.cand_found = found;
        sts.depth_one = (depth_reg == gdbt_pkg::CNT_W'(1));
        sts.fill_zero = (fill_reg == '0);
        sts.emit_ok = !pend_valid_reg || !out_valid_reg;
        sts.out_free = !out_valid_reg;
        sts.pend_valid = pend_valid_reg;
    end

    assign out_valid = out_valid_reg;
    assign vertex = vertex_reg;
    assign last_of_run = last_reg;

endmodule
`default_nettype wire

/* design/gdbt_controller.sv */
`default_nettype none
module gdbt_controller (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire gdbt_pkg::dp_status_t sts,
    output gdbt_pkg::dp_cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_E_RDA,
        S_E_WRA,
        S_E_RDB,
        S_E_WRB,
        S_SCAN,
        S_D_READ,
        S_D_STEP,
        S_D_POPLOAD,
        S_B_DEQ,
        S_B_LOAD,
        S_B_STEP,
        S_FLUSH
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op = gdbt_pkg::DP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = gdbt_pkg::DP_CAPTURE;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.is_edge)
                begin
                    state_next = sts.edge_ok ? S_E_RDA : S_IDLE;
                end
                else if (sts.is_run)
                begin
                    cmd.op = gdbt_pkg::DP_RUN_INIT;
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_E_RDA:
            begin
                cmd.op = gdbt_pkg::DP_EDGE_RDA;
                state_next = S_E_WRA;
            end
            S_E_WRA:
            begin
                cmd.op = gdbt_pkg::DP_EDGE_WRA;
                state_next = S_E_RDB;
            end
            S_E_RDB:
            begin
                cmd.op = gdbt_pkg::DP_EDGE_RDB;
                state_next = S_E_WRB;
            end
            S_E_WRB:
            begin
                cmd.op = gdbt_pkg::DP_EDGE_WRB;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_FLUSH;
                end
                else if (sts.scan_visited)
                begin
                    cmd.op = gdbt_pkg::DP_SCAN_NEXT;
                end
                else if (!sts.is_dfs)
                begin
                    cmd.op = gdbt_pkg::DP_BFS_START;
                    state_next = S_B_DEQ;
                end
                else if (sts.emit_ok)
                begin
                    cmd.op = gdbt_pkg::DP_DFS_START;
                    state_next = S_D_READ;
                end
            end
            S_D_READ:
            begin
                cmd.op = gdbt_pkg::DP_ROW_READ_CUR;
                state_next = S_D_STEP;
            end
            S_D_STEP:
            begin
                if (sts.cand_found)
                begin
                    if (sts.emit_ok)
                    begin
                        cmd.op = gdbt_pkg::DP_DFS_PUSH;
                        state_next = S_D_READ;
                    end
                end
                else
                begin
                    cmd.op = gdbt_pkg::DP_DFS_POP;
                    state_next = sts.depth_one ? S_SCAN : S_D_POPLOAD;
                end
            end
            S_D_POPLOAD:
            begin
                cmd.op = gdbt_pkg::DP_POP_LOAD;
                state_next = S_D_READ;
            end
            S_B_DEQ:
            begin
                cmd.op = gdbt_pkg::DP_BFS_DEQ_READ;
                state_next = S_B_LOAD;
            end
            S_B_LOAD:
            begin
                if (sts.emit_ok)
                begin
                    cmd.op = gdbt_pkg::DP_BFS_DEQ_LOAD;
                    state_next = S_B_STEP;
                end
            end
            S_B_STEP:
            begin
                if (sts.cand_found)
                begin
                    cmd.op = gdbt_pkg::DP_BFS_ENQ;
                end
                else
                begin
                    state_next = sts.fill_zero ? S_SCAN : S_B_DEQ;
                end
            end
            S_FLUSH:
            begin
                if (!sts.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.op = gdbt_pkg::DP_FLUSH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* design/graph_dfs_bfs_traversal.sv */
`default_nettype none
// Graph traversal engine over an undirected adjacency bit matrix of 64 rows. An add-edge
// request (action 0) sets both matrix bits of the edge; an edge with an end at or beyond the
// vertex limit is dropped. A depth-first (action 1) or breadth-first (action 2) request clears
// the visited marks, optionally marks the skipped vertex, and starts a traversal from every
// unvisited vertex below vertex_count (capped at MAX_VERTICES) in ascending order, taking
// neighbors in ascending order. Each visited vertex comes out as one result request, and the
// final one of the run carries last_of_run; a run that visits nothing sends nothing. A run
// scans start vertices in turn; depth-first mode reads the current row and pushes per tree
// edge and pops and reloads per backtrack, and breadth-first mode reads and loads each
// dequeued vertex and enqueues each new neighbor, via a registered adjacency read and a
// lowest-neighbor priority encoder. The next request is taken once the last vertex of a run
// is on the output. Rows are cleared at reset by per-row valid flags, so there is no clearing
// pass. The user must write vertex_count only while the block is idle; it is not enforced.
module graph_dfs_bfs_traversal #(
    parameter int MAX_VERTICES = gdbt_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [gdbt_pkg::CNT_W-1:0]  cfg_wr_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [gdbt_pkg::ACT_W-1:0]  action,
    input  wire logic [gdbt_pkg::VID_W-1:0]  first_vertex,
    input  wire logic [gdbt_pkg::VID_W-1:0]  second_vertex,
    input  wire logic                        skip_enable,
    input  wire logic [gdbt_pkg::VID_W-1:0]  skip_vertex,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [gdbt_pkg::VID_W-1:0]       vertex,
    output logic                             last_of_run
);

    gdbt_pkg::dp_cmd_t    cmd;
    gdbt_pkg::dp_status_t sts;

    // The controller sequences every request; the datapath owns all storage.
    gdbt_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gdbt_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .action        (action),
        .first_vertex  (first_vertex),
        .second_vertex (second_vertex),
        .skip_enable   (skip_enable),
        .skip_vertex   (skip_vertex),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .vertex        (vertex),
        .last_of_run   (last_of_run)
    );

    // A held-back vertex must have been flushed before a new request is taken.
    assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> !sts.pend_valid)
        else $error("pending vertex left over at idle");

    // A vertex is only emitted when the output side can absorb it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == gdbt_pkg::DP_DFS_PUSH || cmd.op == gdbt_pkg::DP_DFS_START ||
         cmd.op == gdbt_pkg::DP_BFS_DEQ_LOAD) |-> sts.emit_ok)
        else $error("vertex emitted while output stage full");

    // Pushing a neighbor requires one to have been found.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == gdbt_pkg::DP_DFS_PUSH || cmd.op == gdbt_pkg::DP_BFS_ENQ) |-> sts.cand_found)
        else $error("neighbor step without a candidate");

    // The final flush marks the result as last of the run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == gdbt_pkg::DP_FLUSH) |=> (out_valid && last_of_run))
        else $error("flush did not present the last vertex");

endmodule
`default_nettype wire
